// ----- design/lmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lmt_pkg
// Types and constants shared by the LCD mode timer and register file.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned BYTE_W     = 8;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_NOP   = 2'd3
  } lmt_cmd_t;

  typedef enum logic [1:0] {
    MODE_HBLANK   = 2'd0,
    MODE_VBLANK   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRANSFER = 2'd3
  } lmt_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HBLANK_TICKS   = 2'd0,
    CFG_VBLANK_TICKS   = 2'd1,
    CFG_SEARCH_TICKS   = 2'd2,
    CFG_TRANSFER_TICKS = 2'd3
  } lmt_cfg_idx_t;

  localparam logic [ADDR_W-1:0] ADDR_LCDC = 16'hFF40;
  localparam logic [ADDR_W-1:0] ADDR_STAT = 16'hFF41;
  localparam logic [ADDR_W-1:0] ADDR_SCY  = 16'hFF42;
  localparam logic [ADDR_W-1:0] ADDR_SCX  = 16'hFF43;
  localparam logic [ADDR_W-1:0] ADDR_LY   = 16'hFF44;
  localparam logic [ADDR_W-1:0] ADDR_LYC  = 16'hFF45;
  localparam logic [ADDR_W-1:0] ADDR_BGP  = 16'hFF47;
  localparam logic [ADDR_W-1:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [ADDR_W-1:0] ADDR_OBP1 = 16'hFF49;
  localparam logic [ADDR_W-1:0] ADDR_WY   = 16'hFF4A;
  localparam logic [ADDR_W-1:0] ADDR_WX   = 16'hFF4B;

  localparam logic [BYTE_W-1:0] UNMAPPED_DATA = 8'hFF;
  localparam logic [BYTE_W-1:0] LCDC_RESET    = 8'h91;
  localparam int unsigned       LCDC_ON_BIT   = 7;

  localparam logic [CFG_DATA_W-1:0] HBLANK_TICKS_RST   = 10'd204;
  localparam logic [CFG_DATA_W-1:0] VBLANK_TICKS_RST   = 10'd456;
  localparam logic [CFG_DATA_W-1:0] SEARCH_TICKS_RST   = 10'd80;
  localparam logic [CFG_DATA_W-1:0] TRANSFER_TICKS_RST = 10'd172;

  // status enable bit positions
  localparam int unsigned STAT_EN_HBL = 0;
  localparam int unsigned STAT_EN_VBL = 1;
  localparam int unsigned STAT_EN_OAM = 2;
  localparam int unsigned STAT_EN_LYC = 3;

  typedef struct packed {
    lmt_cmd_t          cmd;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] write_data;
    logic [BYTE_W-1:0] tick_count;
  } lmt_item_t;

  // register file view seen by the timer
  typedef struct packed {
    logic              lcd_on;
    logic [3:0]        stat_en;
    logic [BYTE_W-1:0] lyc;
    logic              ctrl_off;
  } lmt_view_t;

  // current timer state seen by the register file
  typedef struct packed {
    lmt_mode_t         mode;
    logic [BYTE_W-1:0] line;
    logic              coin;
  } lmt_tstat_t;

  typedef struct packed {
    lmt_mode_t         mode_now;
    logic [BYTE_W-1:0] line_now;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_request;
    logic              frame_done;
  } lmt_tres_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    lmt_mode_t         mode_now;
    logic [BYTE_W-1:0] line_now;
    logic              vblank_irq;
    logic              stat_irq;
    logic              render_request;
    logic              frame_done;
    logic              display_reset;
  } lmt_result_t;

endpackage

`default_nettype wire

// ----- design/lmt_in_if.sv -----
// ----------------------------------------------------------------------------
// lmt_in_if
// Input item channel: command, bus address, write byte and tick count.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmt_in_if
  import lmt_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [15:0] address;
  logic [7:0] write_data;
  logic [7:0] tick_count;

  modport source (output valid, output cmd, output address, output write_data,
                  output tick_count, input ready);
  modport sink   (input valid, input cmd, input address, input write_data,
                  input tick_count, output ready);
endinterface

`default_nettype wire

// ----- design/lmt_out_if.sv -----
// ----------------------------------------------------------------------------
// lmt_out_if
// Result item channel: read byte, mode, line and event pulses.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmt_out_if
  import lmt_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] mode_now;
  logic [7:0] line_now;
  logic       vblank_irq;
  logic       stat_irq;
  logic       render_request;
  logic       frame_done;
  logic       display_reset;

  modport source (output valid, output read_data, output mode_now, output line_now,
                  output vblank_irq, output stat_irq, output render_request,
                  output frame_done, output display_reset, input ready);
  modport sink   (input valid, input read_data, input mode_now, input line_now,
                  input vblank_irq, input stat_irq, input render_request,
                  input frame_done, input display_reset, output ready);
endinterface

`default_nettype wire

// ----- design/lmt_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lmt_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmt_cfg_if
  import lmt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/lmt_regfile.sv -----
// ----------------------------------------------------------------------------
// lmt_regfile
// Bus-visible registers at 0xFF40..0xFF4B: write decode and read mux.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_regfile
  import lmt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire lmt_item_t         item,
  input  wire lmt_tstat_t        tstat,
  output lmt_view_t              view,
  output logic [BYTE_W-1:0]      read_data
);

  logic [BYTE_W-1:0] lcdc_r, lcdc_nxt;
  logic [3:0]        stat_en_r, stat_en_nxt;
  logic [BYTE_W-1:0] scy_r, scy_nxt;
  logic [BYTE_W-1:0] scx_r, scx_nxt;
  logic [BYTE_W-1:0] lyc_r, lyc_nxt;
  logic [BYTE_W-1:0] bgp_r, bgp_nxt;
  logic [BYTE_W-1:0] obp0_r, obp0_nxt;
  logic [BYTE_W-1:0] obp1_r, obp1_nxt;
  logic [BYTE_W-1:0] wy_r, wy_nxt;
  logic [BYTE_W-1:0] wx_r, wx_nxt;
  logic [BYTE_W-1:0] rd_mux;
  logic              is_wr;

  assign is_wr = (item.cmd == CMD_WRITE);

  always_comb begin
    lcdc_nxt    = lcdc_r;
    stat_en_nxt = stat_en_r;
    scy_nxt     = scy_r;
    scx_nxt     = scx_r;
    lyc_nxt     = lyc_r;
    bgp_nxt     = bgp_r;
    obp0_nxt    = obp0_r;
    obp1_nxt    = obp1_r;
    wy_nxt      = wy_r;
    wx_nxt      = wx_r;
    if (is_wr) begin
      case (item.address)
        ADDR_LCDC: lcdc_nxt    = item.write_data;
        ADDR_STAT: stat_en_nxt = item.write_data[6:3];
        ADDR_SCY:  scy_nxt     = item.write_data;
        ADDR_SCX:  scx_nxt     = item.write_data;
        ADDR_LYC:  lyc_nxt     = item.write_data;
        ADDR_BGP:  bgp_nxt     = item.write_data;
        ADDR_OBP0: obp0_nxt    = item.write_data;
        ADDR_OBP1: obp1_nxt    = item.write_data;
        ADDR_WY:   wy_nxt      = item.write_data;
        ADDR_WX:   wx_nxt      = item.write_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (item.address)
      ADDR_LCDC: rd_mux = lcdc_r;
      ADDR_STAT: rd_mux = {1'b0, stat_en_r, tstat.coin, tstat.mode};
      ADDR_SCY:  rd_mux = scy_r;
      ADDR_SCX:  rd_mux = scx_r;
      ADDR_LY:   rd_mux = tstat.line;
      ADDR_LYC:  rd_mux = lyc_r;
      ADDR_BGP:  rd_mux = bgp_r;
      ADDR_OBP0: rd_mux = obp0_r;
      ADDR_OBP1: rd_mux = obp1_r;
      ADDR_WY:   rd_mux = wy_r;
      ADDR_WX:   rd_mux = wx_r;
      default:   rd_mux = UNMAPPED_DATA;
    endcase
    read_data = (item.cmd == CMD_READ) ? rd_mux : '0;
  end

  always_comb begin
    view.lcd_on   = lcdc_r[LCDC_ON_BIT];
    view.stat_en  = stat_en_r;
    view.lyc      = lyc_r;
    view.ctrl_off = is_wr && (item.address == ADDR_LCDC) && !item.write_data[LCDC_ON_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r    <= LCDC_RESET;
      stat_en_r <= '0;
      scy_r     <= '0;
      scx_r     <= '0;
      lyc_r     <= '0;
      bgp_r     <= '0;
      obp0_r    <= '0;
      obp1_r    <= '0;
      wy_r      <= '0;
      wx_r      <= '0;
    end else if (step) begin
      lcdc_r    <= lcdc_nxt;
      stat_en_r <= stat_en_nxt;
      scy_r     <= scy_nxt;
      scx_r     <= scx_nxt;
      lyc_r     <= lyc_nxt;
      bgp_r     <= bgp_nxt;
      obp0_r    <= obp0_nxt;
      obp1_r    <= obp1_nxt;
      wy_r      <= wy_nxt;
      wx_r      <= wx_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/lmt_timer.sv -----
// ----------------------------------------------------------------------------
// lmt_timer
// Tick accumulator, mode sequencer, line counter and interval registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_timer
  import lmt_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES    = 144,
  parameter int unsigned WRAP_LINE        = 153,
  parameter int unsigned TICK_ACCUM_WIDTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire lmt_item_t             item,
  input  wire lmt_view_t             view,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output lmt_tstat_t                 tstat,
  output lmt_tres_t                  tres
);

  localparam int unsigned TW = TICK_ACCUM_WIDTH;
  localparam logic [BYTE_W-1:0] VIS_LINE  = BYTE_W'(VISIBLE_LINES);
  localparam logic [BYTE_W-1:0] WRAP_LN   = BYTE_W'(WRAP_LINE);

  logic [CFG_DATA_W-1:0] hbl_ticks_r, vbl_ticks_r, oam_ticks_r, xfer_ticks_r;

  logic [TW-1:0]     acc_r, acc_nxt;
  lmt_mode_t         mode_r, mode_nxt;
  logic [BYTE_W-1:0] line_r, line_nxt;
  logic              coin_r, coin_nxt;

  logic [TW:0]           acc_sum;
  logic [TW-1:0]         acc_sat;
  logic [CFG_DATA_W-1:0] interval;
  logic [TW-1:0]         interval_ext;
  logic                  take;
  logic [BYTE_W-1:0]     line_inc;
  logic                  hit;
  logic                  vb, st, rq, fd;

  always_comb begin
    acc_sum = {1'b0, acc_r} + {{(TW-7){1'b0}}, item.tick_count};
    acc_sat = acc_sum[TW] ? {TW{1'b1}} : acc_sum[TW-1:0];
    case (mode_r)
      MODE_HBLANK:   interval = hbl_ticks_r;
      MODE_VBLANK:   interval = vbl_ticks_r;
      MODE_SEARCH:   interval = oam_ticks_r;
      MODE_TRANSFER: interval = xfer_ticks_r;
      default:       interval = xfer_ticks_r;
    endcase
    interval_ext = {{(TW-CFG_DATA_W){1'b0}}, interval};
    take     = (acc_sat >= interval_ext);
    line_inc = line_r + 8'd1;
    hit      = (line_inc == view.lyc);

    acc_nxt  = acc_r;
    mode_nxt = mode_r;
    line_nxt = line_r;
    coin_nxt = coin_r;
    vb = 1'b0;
    st = 1'b0;
    rq = 1'b0;
    fd = 1'b0;

    if (item.cmd == CMD_TICK) begin
      acc_nxt = acc_sat;
      if (view.lcd_on && take) begin
        acc_nxt = acc_sat - interval_ext;
        case (mode_r)
          MODE_HBLANK: begin
            line_nxt = line_inc;
            coin_nxt = hit;
            st       = hit && view.stat_en[STAT_EN_LYC];
            if (line_inc == VIS_LINE) begin
              vb       = 1'b1;
              mode_nxt = MODE_VBLANK;
              st       = st || view.stat_en[STAT_EN_VBL];
            end else begin
              mode_nxt = MODE_SEARCH;
              st       = st || view.stat_en[STAT_EN_OAM];
            end
          end
          MODE_VBLANK: begin
            line_nxt = line_inc;
            coin_nxt = hit;
            st       = hit && view.stat_en[STAT_EN_LYC];
            // frame wrap does not recheck the line compare
            if (line_inc >= WRAP_LN) begin
              mode_nxt = MODE_SEARCH;
              line_nxt = '0;
              fd       = 1'b1;
              st       = st || view.stat_en[STAT_EN_VBL];
            end
          end
          MODE_SEARCH: begin
            mode_nxt = MODE_TRANSFER;
          end
          default: begin
            rq       = 1'b1;
            mode_nxt = MODE_HBLANK;
            st       = view.stat_en[STAT_EN_HBL];
          end
        endcase
      end
    end

    if (view.ctrl_off) begin
      acc_nxt  = '0;
      line_nxt = '0;
      mode_nxt = MODE_HBLANK;
    end
  end

  always_comb begin
    tstat.mode = mode_r;
    tstat.line = line_r;
    tstat.coin = coin_r;
    tres.mode_now       = mode_nxt;
    tres.line_now       = line_nxt;
    tres.vblank_irq     = vb;
    tres.stat_irq       = st;
    tres.render_request = rq;
    tres.frame_done     = fd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      mode_r <= MODE_HBLANK;
      line_r <= '0;
      coin_r <= 1'b0;
    end else if (step) begin
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      coin_r <= coin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hbl_ticks_r  <= HBLANK_TICKS_RST;
      vbl_ticks_r  <= VBLANK_TICKS_RST;
      oam_ticks_r  <= SEARCH_TICKS_RST;
      xfer_ticks_r <= TRANSFER_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_HBLANK_TICKS:   hbl_ticks_r  <= cfg_data;
        CFG_VBLANK_TICKS:   vbl_ticks_r  <= cfg_data;
        CFG_SEARCH_TICKS:   oam_ticks_r  <= cfg_data;
        CFG_TRANSFER_TICKS: xfer_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/lcd_mode_timing_and_registers.sv -----
// ----------------------------------------------------------------------------
// lcd_mode_timing_and_registers
// Scanline mode timer with STAT/vblank events and the LCD register file.
//
//   channel  dir  handshake      content
//   in_item  in   valid/ready    cmd, address, write_data, tick_count
//   out_item out  valid/ready    read_data, mode_now, line_now, event pulses
//   cfg_wr   in   valid/ready    index, data (interval registers, ready tied high)
//
// One item per cycle sustained while the result is not stalled.
// The item sits in an input register, one pass of decode, accumulator
// compare/subtract and read mux fills the result register.
// A stalled result holds the item in the input register; the input still
// takes an item when the result is being drained in the same cycle.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_and_registers
  import lmt_pkg::*;
#(
  parameter int unsigned VISIBLE_LINES    = 144,
  parameter int unsigned WRAP_LINE        = 153,
  parameter int unsigned TICK_ACCUM_WIDTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lmt_in_if.sink      in_item,
  lmt_out_if.source   out_item,
  lmt_cfg_if.sink     cfg_wr
);

  lmt_item_t   item_r;
  logic        in_valid_r;
  lmt_result_t res_r;
  logic        res_valid_r;
  logic        advance;

  lmt_view_t         view;
  lmt_tstat_t        tstat;
  lmt_tres_t         tres;
  logic [BYTE_W-1:0] read_data;
  lmt_result_t       res_nxt;

  assign advance       = in_valid_r && (!res_valid_r || out_item.ready);
  assign in_item.ready = !in_valid_r || advance;
  assign cfg_wr.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_item.valid && in_item.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      item_r.cmd        <= lmt_cmd_t'(in_item.cmd);
      item_r.address    <= in_item.address;
      item_r.write_data <= in_item.write_data;
      item_r.tick_count <= in_item.tick_count;
    end
  end

  lmt_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item_r),
    .tstat     (tstat),
    .view      (view),
    .read_data (read_data)
  );

  lmt_timer #(
    .VISIBLE_LINES    (VISIBLE_LINES),
    .WRAP_LINE        (WRAP_LINE),
    .TICK_ACCUM_WIDTH (TICK_ACCUM_WIDTH)
  ) u_timer (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .item     (item_r),
    .view     (view),
    .cfg_we   (cfg_wr.valid && cfg_wr.ready),
    .cfg_idx  (cfg_wr.index),
    .cfg_data (cfg_wr.data),
    .tstat    (tstat),
    .tres     (tres)
  );

  always_comb begin
    res_nxt.read_data      = read_data;
    res_nxt.mode_now       = tres.mode_now;
    res_nxt.line_now       = tres.line_now;
    res_nxt.vblank_irq     = tres.vblank_irq;
    res_nxt.stat_irq       = tres.stat_irq;
    res_nxt.render_request = tres.render_request;
    res_nxt.frame_done     = tres.frame_done;
    res_nxt.display_reset  = view.ctrl_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_item.valid          = res_valid_r;
  assign out_item.read_data      = res_r.read_data;
  assign out_item.mode_now       = res_r.mode_now;
  assign out_item.line_now       = res_r.line_now;
  assign out_item.vblank_irq     = res_r.vblank_irq;
  assign out_item.stat_irq       = res_r.stat_irq;
  assign out_item.render_request = res_r.render_request;
  assign out_item.frame_done     = res_r.frame_done;
  assign out_item.display_reset  = res_r.display_reset;

  // an item leaving the input register always lands in the result register
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_valid_r)
    else $error("result register not filled after advance");

  // a blocked item stays put in the input register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(item_r))
    else $error("input item lost while blocked");

  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.frame_done |->
      res_r.line_now == '0 && res_r.mode_now == MODE_SEARCH)
    else $error("frame done without wrap to line zero");

  a_vblank_mode: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.vblank_irq |-> res_r.mode_now == MODE_VBLANK)
    else $error("vblank pulse outside vblank");

  a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid_r && res_r.render_request |-> res_r.mode_now == MODE_HBLANK)
    else $error("render request outside hblank entry");

endmodule

`default_nettype wire
